@@ sv/cdq_pkg.sv @@
// Shared codes and types for the circular deque.
package cdq_pkg;

  localparam int WORD_W = 32;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam op_t OP_PUSH_FRONT = 2'd0;
  localparam op_t OP_PUSH_BACK  = 2'd1;
  localparam op_t OP_POP_FRONT  = 2'd2;
  localparam op_t OP_POP_BACK   = 2'd3;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic take;  // request transfer on the input channel this cycle
    logic load;  // load the output register this cycle
  } cmd_t;

endpackage

@@ sv/cdq_if.sv @@
// Request and result channel interfaces.
interface cdq_in_if import cdq_pkg::*;;
  logic  valid;
  logic  ready;
  op_t   op;
  word_t push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface cdq_out_if import cdq_pkg::*;;
  logic    valid;
  logic    ready;
  word_t   pop_value;
  status_t status;
  logic    now_empty;
  logic    now_full;

  modport source (output valid, output pop_value, output status, output now_empty,
                  output now_full, input ready);
  modport sink   (input valid, input pop_value, input status, input now_empty,
                  input now_full, output ready);
endinterface

@@ sv/cdq_ctrl.sv @@
// Handshake controller: sequences one request at a time into the output register.
module cdq_ctrl import cdq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FIN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // Take a request only when the output register is free or drains this cycle.
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign cmd.take  = in_valid && in_ready;
  assign cmd.load  = (state_r == S_FIN);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.take) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ sv/cdq_dpath.sv @@
// Deque datapath: slot memory, front/rear pointers and the result register.
module cdq_dpath import cdq_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cmd_t    cmd,
  input  op_t     op,
  input  word_t   push_value,
  output word_t   pop_value,
  output status_t status,
  output logic    now_empty,
  output logic    now_full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] ZERO = '0;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    return (p == LAST) ? ZERO : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] prev_pos(input logic [PTR_W-1:0] p);
    return (p == ZERO) ? LAST : p - PTR_W'(1);
  endfunction

  word_t slots_r [DEPTH];
  word_t rd_data_r;

  logic [PTR_W-1:0] front_r, front_nxt;
  logic [PTR_W-1:0] rear_r, rear_nxt;
  logic             empty_r, empty_nxt;

  logic [PTR_W-1:0] wr_addr, rd_addr;
  logic             wr_en, rd_en;
  logic             full_now;

  status_t pend_status_r, pend_status_nxt;
  logic    pend_popok_r, pend_popok_nxt;
  logic    pend_empty_r, pend_full_r;

  word_t   out_pop_value_r;
  status_t out_status_r;
  logic    out_empty_r, out_full_r;

  assign full_now = !empty_r && (next_pos(rear_r) == front_r);

  always_comb begin
    front_nxt       = front_r;
    rear_nxt        = rear_r;
    empty_nxt       = empty_r;
    wr_en           = 1'b0;
    wr_addr         = front_r;
    rd_en           = 1'b0;
    rd_addr         = front_r;
    pend_status_nxt = ST_DONE;
    pend_popok_nxt  = 1'b0;
    if (cmd.take) begin
      if (!op[1]) begin
        if (full_now) begin
          pend_status_nxt = ST_FULL;
        end else if (empty_r) begin
          // First word: push front lands in the last slot, push back in slot 0.
          wr_addr   = (op == OP_PUSH_FRONT) ? LAST : ZERO;
          front_nxt = wr_addr;
          rear_nxt  = wr_addr;
          empty_nxt = 1'b0;
          wr_en     = 1'b1;
        end else if (op == OP_PUSH_FRONT) begin
          front_nxt = prev_pos(front_r);
          wr_addr   = front_nxt;
          wr_en     = 1'b1;
        end else begin
          rear_nxt = next_pos(rear_r);
          wr_addr  = rear_nxt;
          wr_en    = 1'b1;
        end
      end else begin
        if (empty_r) begin
          pend_status_nxt = ST_EMPTY;
        end else begin
          rd_en          = 1'b1;
          pend_popok_nxt = 1'b1;
          if (front_r == rear_r) begin
            // Last word out: return both pointers to zero.
            rd_addr   = front_r;
            front_nxt = ZERO;
            rear_nxt  = ZERO;
            empty_nxt = 1'b1;
          end else if (op == OP_POP_FRONT) begin
            rd_addr   = front_r;
            front_nxt = next_pos(front_r);
          end else begin
            rd_addr  = rear_r;
            rear_nxt = prev_pos(rear_r);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slots_r[wr_addr] <= push_value;
    if (rd_en) rd_data_r <= slots_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= ZERO;
      rear_r  <= ZERO;
      empty_r <= 1'b1;
    end else begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
    end
  end

  // Hold the result flags until the read data arrives.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_status_r <= pend_status_nxt;
      pend_popok_r  <= pend_popok_nxt;
      pend_empty_r  <= empty_nxt;
      pend_full_r   <= !empty_nxt && (next_pos(rear_nxt) == front_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_pop_value_r <= pend_popok_r ? rd_data_r : '0;
      out_status_r    <= pend_status_r;
      out_empty_r     <= pend_empty_r;
      out_full_r      <= pend_full_r;
    end
  end

  assign pop_value = out_pop_value_r;
  assign status    = out_status_r;
  assign now_empty = out_empty_r;
  assign now_full  = out_full_r;

endmodule

@@ sv/circular_deque.sv @@
// Circular deque of signed 32-bit words with push/pop at both ends. For each request,
// the accept cycle moves a pointer and writes or reads one slot, and the next cycle
// loads the result register from the registered slot read port.
// One request is in flight at a time; a new one is taken once the previous result
// has transferred or transfers in the same cycle. Refused pushes and pops report
// through status and leave the queue unchanged. No clearing pass follows reset.
module circular_deque import cdq_pkg::*; #(
  parameter int DEPTH = 8
) (
  input logic          clk,
  input logic          rst_n,
  cdq_in_if.sink       in_ch,
  cdq_out_if.source    out_ch
);

  cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  cdq_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .op         (in_ch.op),
    .push_value (in_ch.push_value),
    .pop_value  (out_ch.pop_value),
    .status     (out_ch.status),
    .now_empty  (out_ch.now_empty),
    .now_full   (out_ch.now_full)
  );

endmodule

@@ sv/cdq_checker.sv @@
// Port-level checks for the circular deque, bound to the top level.
module cdq_checker import cdq_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input word_t   out_pop_value,
  input status_t out_status,
  input logic    out_now_empty,
  input logic    out_now_full
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pop_value)
      && $stable(out_status))
    else $error("result changed while stalled");

  // One request in flight: no transfer right after a transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while one is in flight");

  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_now_empty && out_now_full))
    else $error("queue reported empty and full");

  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_now_full && out_pop_value == '0)
    else $error("refused push without full queue");

  a_empty_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_now_empty && out_pop_value == '0)
    else $error("refused pop without empty queue");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_pop_value (out_ch.pop_value),
  .out_status    (out_ch.status),
  .out_now_empty (out_ch.now_empty),
  .out_now_full  (out_ch.now_full)
);

@@ sim/circular_deque_tb.sv @@
// Self-checking testbench for the circular deque: random handshakes, predictor and scoreboard.
`timescale 1ns / 100ps

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int DEPTH = 8;
  localparam int N_RANDOM = 1400;
  localparam int RX_HOLD_CYCLES = 40;

  typedef struct {
    op_t   op;
    word_t push_value;
    bit    hold_rx;      // receiver holds off once this request transfers
    bit    drain_first;  // sender waits for every result before offering this
  } req_t;

  typedef struct packed {
    word_t   pop_value;
    status_t status;
    logic    now_empty;
    logic    now_full;
  } result_t;

  logic clk;
  logic rst_n;

  cdq_in_if  in_ch ();
  cdq_out_if out_ch ();

  circular_deque #(.DEPTH(DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted deque contents
  word_t dq_slots [DEPTH];
  int    dq_front;
  int    dq_rear;
  bit    dq_empty;

  req_t    pending_reqs[$];
  result_t pending_results[$];
  req_t    offered;

  bit in_xfer;
  bit out_xfer;
  int hold_req;
  int hold_seen;
  int n_errors;
  int n_accepted;
  int n_checked;
  int n_done, n_refused_full, n_refused_empty;
  int n_seen_full, n_seen_empty;
  int n_holds, n_drains;
  int tx_gap, tx_burst;
  int rx_gap, rx_burst, rx_hold;

  function automatic bit deque_full();
    return !dq_empty && ((dq_rear + 1) % DEPTH) == dq_front;
  endfunction

  function automatic void deque_predict(input op_t op, input word_t val, output result_t r);
    r = '0;
    r.status = ST_DONE;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      if (deque_full()) begin
        r.status = ST_FULL;
      end else if (dq_empty) begin
        // first word lands at the end that matches the push side
        dq_front = (op == OP_PUSH_FRONT) ? DEPTH - 1 : 0;
        dq_rear = dq_front;
        dq_slots[dq_front] = val;
        dq_empty = 1'b0;
      end else if (op == OP_PUSH_FRONT) begin
        dq_front = (dq_front + DEPTH - 1) % DEPTH;
        dq_slots[dq_front] = val;
      end else begin
        dq_rear = (dq_rear + 1) % DEPTH;
        dq_slots[dq_rear] = val;
      end
    end else begin
      if (dq_empty) begin
        r.status = ST_EMPTY;
      end else if (dq_front == dq_rear) begin
        // last word out: pointers return to zero
        r.pop_value = dq_slots[dq_front];
        dq_front = 0;
        dq_rear = 0;
        dq_empty = 1'b1;
      end else if (op == OP_POP_FRONT) begin
        r.pop_value = dq_slots[dq_front];
        dq_front = (dq_front + 1) % DEPTH;
      end else begin
        r.pop_value = dq_slots[dq_rear];
        dq_rear = (dq_rear + DEPTH - 1) % DEPTH;
      end
    end
    r.now_empty = dq_empty;
    r.now_full = deque_full();
  endfunction

  // Mostly short gaps, a few long ones, and occasional runs with no gaps at all
  function automatic int idle_gap(inout int burst);
    int r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) burst = $urandom_range(20, 60);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 11))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic req_t make_req(input op_t op, input word_t val);
    req_t q;
    q.op = op;
    q.push_value = val;
    q.hold_rx = 1'b0;
    q.drain_first = 1'b0;
    return q;
  endfunction

  function automatic req_t rand_req(input int push_pct);
    op_t op;
    if ($urandom_range(0, 99) < push_pct)
      op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    else
      op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    return make_req(op, pick_word());
  endfunction

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_PUSH_FRONT;
    in_ch.push_value = '0;
    out_ch.ready = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("circular_deque verification failed");
    $finish;
  end

  // Scoreboard: check results first, then predict the newly accepted request
  always @(posedge clk) begin
    result_t got, want;
    result_t pred;
    in_xfer = rst_n && in_ch.valid && in_ch.ready;
    out_xfer = rst_n && out_ch.valid && out_ch.ready;
    if (out_xfer) begin
      got.pop_value = out_ch.pop_value;
      got.status = out_ch.status;
      got.now_empty = out_ch.now_empty;
      got.now_full = out_ch.now_full;
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: pop_value %0d status %0d", got.pop_value,
               got.status);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (got.pop_value !== want.pop_value) begin
          $error("pop_value: expected %0d, got %0d", want.pop_value, got.pop_value);
          n_errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          n_errors++;
        end
        if (got.now_empty !== want.now_empty) begin
          $error("now_empty: expected %0d, got %0d", want.now_empty, got.now_empty);
          n_errors++;
        end
        if (got.now_full !== want.now_full) begin
          $error("now_full: expected %0d, got %0d", want.now_full, got.now_full);
          n_errors++;
        end
      end
    end
    if (in_xfer) begin
      deque_predict(in_ch.op, in_ch.push_value, pred);
      pending_results.push_back(pred);
      n_accepted++;
      case (pred.status)
        ST_DONE:  n_done++;
        ST_FULL:  n_refused_full++;
        ST_EMPTY: n_refused_empty++;
        default: ;
      endcase
      if (pred.now_full) n_seen_full++;
      if (pred.now_empty) n_seen_empty++;
      if (offered.hold_rx) hold_req++;
    end
  end

  // Request driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && !in_xfer) begin
        // hold the offer until it transfers
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain_first && pending_results.size() != 0)) begin
        offered = pending_reqs.pop_front();
        if (offered.drain_first) n_drains++;
        in_ch.op <= offered.op;
        in_ch.push_value <= offered.push_value;
        in_ch.valid <= 1'b1;
        tx_gap = idle_gap(tx_burst);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        rx_hold = RX_HOLD_CYCLES;
        n_holds++;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        rx_gap = idle_gap(rx_burst);
      end
    end
  end

  initial begin
    int push_pct, blk_len, n;
    word_t edge_words [4];

    dq_front = 0;
    dq_rear = 0;
    dq_empty = 1'b1;
    foreach (dq_slots[i]) dq_slots[i] = '0;

    edge_words[0] = 32'sh7FFF_FFFF;
    edge_words[1] = 32'sh8000_0000;
    edge_words[2] = 32'sh5555_5555;
    edge_words[3] = 32'shAAAA_AAAA;

    // Directed: empty pops, pushes onto empty at each end, last-word pops,
    // fill to full with extreme words, refused pushes, wrap, drain.
    pending_reqs.push_back(make_req(OP_POP_FRONT, word_t'($urandom)));
    pending_reqs.push_back(make_req(OP_POP_BACK, word_t'($urandom)));
    pending_reqs.push_back(make_req(OP_PUSH_FRONT, 32'sh7FFF_FFFF));
    pending_reqs.push_back(make_req(OP_POP_BACK, '0));
    pending_reqs.push_back(make_req(OP_PUSH_BACK, 32'sh8000_0000));
    pending_reqs.push_back(make_req(OP_POP_FRONT, '1));
    for (int i = 0; i < DEPTH; i++)
      pending_reqs.push_back(make_req(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                                      (i < 4) ? edge_words[i] : word_t'(i - 6)));
    pending_reqs.push_back(make_req(OP_PUSH_FRONT, 32'sh1234_5678));
    pending_reqs.push_back(make_req(OP_PUSH_BACK, 32'sh8765_4321));
    pending_reqs.push_back(make_req(OP_POP_FRONT, '0));
    pending_reqs.push_back(make_req(OP_PUSH_BACK, '1));
    for (int i = 0; i < DEPTH; i++)
      pending_reqs.push_back(make_req(i[0] ? OP_POP_BACK : OP_POP_FRONT, word_t'($urandom)));

    // Random: alternate fill-biased, drain-biased and balanced runs so that
    // full and empty are both reached often and the pointers wrap.
    n = 0;
    while (n < N_RANDOM) begin
      blk_len = $urandom_range(4, 40);
      case ($urandom_range(0, 9))
        0, 1, 2: push_pct = 85;
        3, 4, 5: push_pct = 15;
        6, 7, 8: push_pct = 50;
        default: push_pct = $urandom_range(0, 100);
      endcase
      for (int i = 0; i < blk_len; i++) begin
        pending_reqs.push_back(rand_req(push_pct));
        n++;
      end
    end
    pending_reqs[200].hold_rx = 1'b1;
    pending_reqs[800].hold_rx = 1'b1;
    pending_reqs[500].drain_first = 1'b1;
    pending_reqs[1100].drain_first = 1'b1;
    for (int i = 30; i < pending_reqs.size(); i++)
      if ($urandom_range(0, 99) == 0) pending_reqs[i].drain_first = 1'b1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_reqs.size() != 0 || in_ch.valid) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d requests: %0d done, %0d refused full, %0d refused empty",
             n_accepted, n_done, n_refused_full, n_refused_empty);
    $display("%0d results checked; full after %0d, empty after %0d; %0d hold-offs, %0d drains",
             n_checked, n_seen_full, n_seen_empty, n_holds, n_drains);
    if (n_errors == 0 && pending_results.size() == 0)
      $display("circular_deque verification clean");
    else
      $display("circular_deque verification failed");
    $finish;
  end

endmodule
